// File: rtl/core/sfda_pkg.sv
// Shared constants and types for the sample FIFO with drain-and-average.
package sfda_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FILL_W   = 4;
  localparam int ACTION_W = 2;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int MEAN_MAX_DEF   = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_DRAIN = 2'd2
  } action_t;

endpackage

// File: rtl/core/sfda_if.sv
// Request and response channel interfaces.
interface sfda_req_if;
  logic                          valid;
  logic                          ready;
  logic [sfda_pkg::ACTION_W-1:0] action;
  logic [sfda_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, action, sample, input ready);
  modport sink   (input valid, action, sample, output ready);
endinterface

interface sfda_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sfda_pkg::SAMPLE_W-1:0] data;
  logic                          was_empty;
  logic [sfda_pkg::FILL_W-1:0]   fill_count;
  logic                          overflowed;

  modport source (output valid, data, was_empty, fill_count, overflowed, input ready);
  modport sink   (input valid, data, was_empty, fill_count, overflowed, output ready);
endinterface

// File: rtl/core/sfda_store.sv
// Sample memory: one write port, one registered read port.
module sfda_store #(
  parameter int FIFO_DEPTH = sfda_pkg::FIFO_DEPTH_DEF,
  parameter int PTR_W      = $clog2(FIFO_DEPTH)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [PTR_W-1:0]              wr_addr,
  input  logic [sfda_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [PTR_W-1:0]              rd_addr,
  output logic [sfda_pkg::SAMPLE_W-1:0] rd_data
);

  logic [sfda_pkg::SAMPLE_W-1:0] mem [FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/sfda_div.sv
// Restoring divider, one quotient bit per cycle.
module sfda_div #(
  parameter int SUM_W = 20,
  parameter int DIV_W = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [SUM_W-1:0]              dividend,
  input  logic [DIV_W-1:0]              divisor,
  output logic                          done,
  output logic [sfda_pkg::SAMPLE_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] steps;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial    = {rem, quo[SUM_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo[sfda_pkg::SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= CNT_W'(SUM_W);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (steps != '0) begin
      // shift the next dividend bit into the remainder, subtract when it fits
      if (fits) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIV_W-1:0];
      end
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

endmodule

// File: rtl/core/sample_fifo_with_drain_average.sv
// Sample FIFO with drain-and-average.
// Push, unknown action, and pop/drain on empty: result registered in the cycle after the accept.
// Pop: one registered memory read, then ST_POP loads the result. Drain: min(count, MEAN_MAX)
// memory reads are summed in ST_SUM, then ST_DIV divides by that number and registers the mean.
// One item at a time; next item accepted once the result register is free.
// Synchronous reset clears pointers, count, overflow flag; sample memory is not cleared.
module sample_fifo_with_drain_average #(
  parameter int FIFO_DEPTH = sfda_pkg::FIFO_DEPTH_DEF,
  parameter int MEAN_MAX   = sfda_pkg::MEAN_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  sfda_req_if.sink          req,
  sfda_rsp_if.source        rsp
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int USE_W = $clog2(MEAN_MAX + 1);
  localparam int SUM_W = sfda_pkg::SAMPLE_W + USE_W;
  localparam int SW    = sfda_pkg::SAMPLE_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_POP  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  state_t           state;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] entry_count;
  logic             overflow_flag;
  logic [PTR_W-1:0] walk_addr;
  logic [USE_W-1:0] left;
  logic [USE_W-1:0] used;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;

  logic             out_valid;
  logic [SW-1:0]    out_data;
  logic             out_empty;

  logic             accept;
  logic             is_empty;
  logic             mem_wr;
  logic [PTR_W-1:0] mem_rd_addr;
  logic [SW-1:0]    mem_rd_data;
  logic             div_start;
  logic             div_done;
  logic [SW-1:0]    div_quo;
  logic [USE_W-1:0] take_cnt;
  logic [PTR_W:0]   count_inc;
  logic [PTR_W:0]   rd_end;
  logic [31:0]      count_ext;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= (PTR_W+1)'(FIFO_DEPTH)) ? '0 : n[PTR_W-1:0];
  endfunction

  assign req.ready   = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept      = req.valid && req.ready;
  assign is_empty    = entry_count == '0;
  assign mem_wr      = accept && (sfda_pkg::action_t'(req.action) == sfda_pkg::ACT_PUSH);
  assign mem_rd_addr = (state == ST_IDLE) ? rd_ptr : walk_addr;
  assign take_cnt    = (32'(entry_count) > MEAN_MAX) ? USE_W'(MEAN_MAX)
                                                     : USE_W'(entry_count);
  assign count_inc   = {1'b0, entry_count} + 1'b1;
  assign rd_end      = {1'b0, rd_ptr} + {1'b0, entry_count};
  assign sum_next    = sum + SUM_W'(mem_rd_data);
  assign div_start   = (state == ST_SUM) && (left == USE_W'(1));
  assign count_ext   = 32'(entry_count);

  assign rsp.valid      = out_valid;
  assign rsp.data       = out_data;
  assign rsp.was_empty  = out_empty;
  assign rsp.fill_count = count_ext[sfda_pkg::FILL_W-1:0];
  assign rsp.overflowed = overflow_flag;

  sfda_store #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .PTR_W      (PTR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (wr_ptr),
    .wr_data (req.sample),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  sfda_div #(
    .SUM_W (SUM_W),
    .DIV_W (USE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (used),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      entry_count   <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (sfda_pkg::action_t'(req.action))
              sfda_pkg::ACT_PUSH: begin
                wr_ptr <= ptr_inc(wr_ptr);
                // count reaching depth wraps to zero and latches overflow
                if (count_inc == (PTR_W+1)'(FIFO_DEPTH)) begin
                  entry_count   <= '0;
                  overflow_flag <= 1'b1;
                end else begin
                  entry_count <= count_inc[PTR_W-1:0];
                end
                out_valid <= 1'b1;
              end
              sfda_pkg::ACT_POP: begin
                if (is_empty) begin
                  out_valid <= 1'b1;
                end else begin
                  rd_ptr      <= ptr_inc(rd_ptr);
                  entry_count <= entry_count - 1'b1;
                  state       <= ST_POP;
                end
              end
              sfda_pkg::ACT_DRAIN: begin
                if (is_empty) begin
                  out_valid <= 1'b1;
                end else begin
                  // drop every entry now; only up to MEAN_MAX of the oldest are read back
                  if (rd_end >= (PTR_W+1)'(FIFO_DEPTH)) begin
                    rd_ptr <= PTR_W'(rd_end - (PTR_W+1)'(FIFO_DEPTH));
                  end else begin
                    rd_ptr <= rd_end[PTR_W-1:0];
                  end
                  entry_count <= '0;
                  state       <= ST_SUM;
                end
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        ST_POP: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_SUM: begin
          if (left == USE_W'(1)) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        // hold the result fields while a beat waits; load them only on accept
        if (accept) begin
          out_data  <= '0;
          out_empty <= (sfda_pkg::action_t'(req.action) == sfda_pkg::ACT_POP ||
                        sfda_pkg::action_t'(req.action) == sfda_pkg::ACT_DRAIN) && is_empty;
          walk_addr <= ptr_inc(rd_ptr);
          left      <= take_cnt;
          used      <= take_cnt;
          sum       <= '0;
        end
      end
      ST_POP: begin
        out_data <= mem_rd_data;
      end
      ST_SUM: begin
        sum       <= sum_next;
        left      <= left - 1'b1;
        walk_addr <= ptr_inc(walk_addr);
      end
      ST_DIV: begin
        out_data <= div_quo;
      end
      default: begin
        out_data <= '0;
      end
    endcase
  end

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the sample FIFO with drain-and-average.
module tb;

  localparam int DEPTH        = sfda_pkg::FIFO_DEPTH_DEF;
  localparam int MEAN_CAP     = sfda_pkg::MEAN_MAX_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_LEN   = 40;
  localparam int HOLD_LEN     = 300;
  localparam int PHASE_ITEMS  = 225;
  localparam logic [sfda_pkg::ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [sfda_pkg::SAMPLE_W-1:0] data;
    logic                          was_empty;
    logic [sfda_pkg::FILL_W-1:0]   fill_count;
    logic                          overflowed;
  } resp_t;

  class sample_ring_scoreboard;
    logic [sfda_pkg::SAMPLE_W-1:0] ring[DEPTH];
    int    wr_idx, rd_idx, held;
    logic  sticky_ovf;
    resp_t expected_responses[$];
    int    errors, n_checked, n_push, n_pop, n_drain, n_empty, n_capped;
    int    n_wrap, n_unknown;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_idx = 0; rd_idx = 0; held = 0; sticky_ovf = 1'b0;
      errors = 0; n_checked = 0; n_push = 0; n_pop = 0; n_drain = 0;
      n_empty = 0; n_capped = 0; n_wrap = 0; n_unknown = 0;
    endfunction

    function int fill_level();
      return held;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    function logic [sfda_pkg::SAMPLE_W-1:0] take_oldest();
      logic [sfda_pkg::SAMPLE_W-1:0] v;
      v = ring[rd_idx];
      rd_idx = (rd_idx + 1) % DEPTH;
      held--;
      return v;
    endfunction

    // Advance the ring model by one action and queue the response it implies.
    function void record_action(logic [sfda_pkg::ACTION_W-1:0] act,
                                logic [sfda_pkg::SAMPLE_W-1:0] smp);
      resp_t r;
      logic [31:0] sum;
      int used;
      r = '0;
      case (act)
        sfda_pkg::ACT_PUSH: begin
          n_push++;
          ring[wr_idx] = smp;
          wr_idx = (wr_idx + 1) % DEPTH;
          held++;
          if (held >= DEPTH) begin
            held = 0;
            sticky_ovf = 1'b1;
            n_wrap++;
          end
        end
        sfda_pkg::ACT_POP: begin
          n_pop++;
          if (held == 0) begin
            r.was_empty = 1'b1;
            n_empty++;
          end else begin
            r.data = take_oldest();
          end
        end
        sfda_pkg::ACT_DRAIN: begin
          n_drain++;
          if (held == 0) begin
            r.was_empty = 1'b1;
            n_empty++;
          end else begin
            sum = '0;
            used = 0;
            if (held > MEAN_CAP) n_capped++;
            while (held > 0) begin
              if (used < MEAN_CAP) begin
                sum += take_oldest();
                used++;
              end else begin
                void'(take_oldest());
              end
            end
            r.data = sfda_pkg::SAMPLE_W'(sum / used);
          end
        end
        default: n_unknown++;
      endcase
      r.fill_count = sfda_pkg::FILL_W'(held);
      r.overflowed = sticky_ovf;
      expected_responses.push_back(r);
    endfunction

    function bit field_ok(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_response(resp_t got);
      resp_t e;
      bit ok;
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none actual %s",
                 $time, $sformatf("data=%0d empty=%0b fill=%0d ovf=%0b",
                 got.data, got.was_empty, got.fill_count, got.overflowed));
        errors++;
        return;
      end
      e = expected_responses.pop_front();
      n_checked++;
      ok = field_ok("data", e.data, got.data);
      ok = field_ok("was_empty", e.was_empty, got.was_empty) && ok;
      ok = field_ok("fill_count", e.fill_count, got.fill_count) && ok;
      ok = field_ok("overflowed", e.overflowed, got.overflowed) && ok;
      if (!ok) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   tx_idle_pct = 11;
  int   rx_idle_pct = 79;
  int   rx_hold_cycles = 0;
  int   items_sent = 0;
  int   stall_cycles = 0;
  sample_ring_scoreboard sb = new();

  sfda_req_if req_ch();
  sfda_rsp_if rsp_ch();

  sample_fifo_with_drain_average u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Response side: check each beat, then pick next ready.
  initial begin
    resp_t got;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.data       = rsp_ch.data;
        got.was_empty  = rsp_ch.was_empty;
        got.fill_count = rsp_ch.fill_count;
        got.overflowed = rsp_ch.overflowed;
        sb.check_response(got);
      end
      if (rx_hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles, %0d responses outstanding",
               $time, stall_cycles, sb.pending());
      $display("FAIL sample_fifo_with_drain_average");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Drive one request beat; returns at the edge where it was taken.
  task automatic send_item(input logic [sfda_pkg::ACTION_W-1:0] act,
                           input logic [sfda_pkg::SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.sample <= smp;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.record_action(act, smp);
    if (act != ACT_UNKNOWN) items_sent++;
  endtask

  task automatic wait_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [sfda_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return sfda_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n);
    int target, kind, len;
    target = items_sent + n;
    while (items_sent < target) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        // fill with a few pops mixed in, then drain
        len = $urandom_range(1, DEPTH - 1);
        repeat (len) begin
          if ($urandom_range(5) == 0) begin
            send_item(sfda_pkg::ACT_POP, sfda_pkg::SAMPLE_W'($urandom));
          end else begin
            send_item(sfda_pkg::ACT_PUSH, rand_sample());
          end
        end
        send_item(sfda_pkg::ACT_DRAIN, sfda_pkg::SAMPLE_W'($urandom));
      end else if (kind < 7) begin
        // push up to the wrap point
        len = DEPTH - sb.fill_level();
        repeat (len) send_item(sfda_pkg::ACT_PUSH, rand_sample());
      end else if (kind < 9) begin
        repeat (8) begin
          if ($urandom_range(1) == 0) begin
            send_item(sfda_pkg::ACT_PUSH, rand_sample());
          end else begin
            send_item(sfda_pkg::ACT_POP, sfda_pkg::SAMPLE_W'($urandom));
          end
        end
      end else begin
        send_item(sfda_pkg::ACTION_W'($urandom_range(3)), sfda_pkg::SAMPLE_W'($urandom));
      end
    end
  endtask

  initial begin
    req_ch.valid  <= 1'b0;
    req_ch.action <= sfda_pkg::ACT_PUSH;
    req_ch.sample <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty buffer, unknown action
    send_item(sfda_pkg::ACT_POP, '0);
    send_item(sfda_pkg::ACT_DRAIN, '1);
    send_item(ACT_UNKNOWN, '1);
    // drain more than the mean window: full-scale samples fill the window, one zero beyond it
    repeat (MEAN_CAP) send_item(sfda_pkg::ACT_PUSH, '1);
    send_item(sfda_pkg::ACT_PUSH, '0);
    send_item(sfda_pkg::ACT_DRAIN, '0);
    // fill to depth so the count wraps and the flag sticks
    for (int i = 0; i < DEPTH; i++) begin
      send_item(sfda_pkg::ACT_PUSH, i[0] ? 16'hAAAA : 16'h5555);
    end
    send_item(sfda_pkg::ACT_POP, '0);
    wait_results();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 79 : 0;
      rx_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 11 : 0;
      if (phase == 1) begin
        run_random(PHASE_ITEMS / 2);
        rx_hold_cycles = HOLD_LEN;
        run_random(PHASE_ITEMS / 2);
      end else begin
        run_random(PHASE_ITEMS);
      end
      wait_results();
    end

    repeat (SETTLE_LEN) @(posedge clk);
    $display("Checked %0d responses: %0d pushes, %0d pops, %0d drains, %0d on empty",
             sb.n_checked, sb.n_push, sb.n_pop, sb.n_drain, sb.n_empty);
    $display("Drains past the mean window %0d, count wraps %0d, unknown actions %0d",
             sb.n_capped, sb.n_wrap, sb.n_unknown);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS sample_fifo_with_drain_average");
    end else begin
      $display("FAIL sample_fifo_with_drain_average");
    end
    $finish;
  end

endmodule
